// ----- hdl/ppbw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppbw_pkg
// Shared types and constants of the point projection and bilinear weight core.
// ----------------------------------------------------------------------------
package ppbw_pkg;

	localparam int FRAC_BITS_DEF = 16;
	localparam int DIM_BITS_DEF  = 12;
	localparam int CFG_DATA_W    = 64;
	localparam int CFG_IDX_W     = 3;
	localparam int IDX_W         = DIM_BITS_DEF + 17;
	localparam int WGT_W         = 17;

	localparam logic [CFG_IDX_W-1:0] REG_ROW0_A = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_B = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_A = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_B = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_A = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_B = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd7;

	localparam logic [12:0] WIDTH_RESET  = 13'd640;
	localparam logic [12:0] HEIGHT_RESET = 13'd480;

	typedef struct packed {
		logic signed [31:0] pt_x;
		logic signed [31:0] pt_y;
		logic signed [31:0] pt_z;
		logic               last_point;
	} point_t;

	typedef struct packed {
		logic signed [IDX_W-1:0] pixel_index;
		logic                    in_bounds;
		logic [WGT_W-1:0]        weight_tl;
		logic [WGT_W-1:0]        weight_tr;
		logic [WGT_W-1:0]        weight_bl;
		logic [WGT_W-1:0]        weight_br;
		logic                    last_out;
	} result_t;

endpackage
`default_nettype wire

// ----- hdl/ppbw_divider.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ppbw_divider
// Pipelined restoring divider: floor(|num| * 2^FRAC / den), clamped to the
// coordinate limit, then signed floor. One quotient bit per stage.
// ----------------------------------------------------------------------------
module ppbw_divider #(
	parameter int FRAC_BITS = ppbw_pkg::FRAC_BITS_DEF,
	parameter int NUM_W     = 50,
	parameter int TAG_W     = 8
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         in_valid,
	input  wire signed [NUM_W-1:0]      num,
	input  wire        [NUM_W-2:0]      den,
	input  wire        [TAG_W-1:0]      tag_in,
	output logic                        out_valid,
	output logic signed [FRAC_BITS+16:0] coord,
	output logic       [TAG_W-1:0]      tag_out
);
	// Dividend |num| << FRAC, bits processed from the top, one per stage.
	localparam int DV_W  = NUM_W - 1 + FRAC_BITS;
	localparam int N     = DV_W;
	localparam int R_W   = NUM_W;
	localparam int Q_W   = DV_W;
	localparam int C_W   = FRAC_BITS + 17;
	localparam logic [Q_W-1:0] LIM = Q_W'(64'd32767 << FRAC_BITS);

	logic [N:0]              v_q;
	logic [DV_W-1:0]         dv_q  [N+1];
	logic [R_W-1:0]          r_q   [N+1];
	logic [Q_W-1:0]          q_q   [N+1];
	logic [NUM_W-2:0]        d_q   [N+1];
	logic                    neg_q [N+1];
	logic [TAG_W-1:0]        tag_q [N+1];

	logic [NUM_W-1:0] mag;
	assign mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[N-1:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		dv_q[0]  <= {mag[NUM_W-2:0], {FRAC_BITS{1'b0}}};
		r_q[0]   <= '0;
		q_q[0]   <= '0;
		d_q[0]   <= den;
		neg_q[0] <= num[NUM_W-1];
		tag_q[0] <= tag_in;
	end

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [R_W-1:0] sh;
		logic [R_W-1:0] diff;
		assign sh   = {r_q[k][R_W-2:0], dv_q[k][DV_W-1]};
		assign diff = sh - {1'b0, d_q[k]};
		always_ff @(posedge clk) begin
			dv_q[k+1]  <= {dv_q[k][DV_W-2:0], 1'b0};
			d_q[k+1]   <= d_q[k];
			neg_q[k+1] <= neg_q[k];
			tag_q[k+1] <= tag_q[k];
			if (sh >= {1'b0, d_q[k]}) begin
				r_q[k+1] <= diff;
				q_q[k+1] <= {q_q[k][Q_W-2:0], 1'b1};
			end else begin
				r_q[k+1] <= sh;
				q_q[k+1] <= {q_q[k][Q_W-2:0], 1'b0};
			end
		end
	end

	logic            sat;
	logic [C_W-1:0]  qm;
	logic            rnz;
	assign sat = q_q[N] >= LIM;
	assign qm  = sat ? C_W'(LIM) : C_W'(q_q[N]);
	assign rnz = !sat && (r_q[N] != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= v_q[N];
		end
	end

	always_ff @(posedge clk) begin
		tag_out <= tag_q[N];
		if (neg_q[N]) begin
			coord <= -$signed(qm) - $signed(C_W'(rnz));
		end else begin
			coord <= $signed(qm);
		end
	end
endmodule
`default_nettype wire

// ----- hdl/project_point_bilinear_weights_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// project_point_bilinear_weights_core
// Projects a Q16.16 point through a 3x4 camera matrix and gives the pixel
// index, bounds flag and four bilinear weights.
// ----------------------------------------------------------------------------
// One point is taken in every cycle and one result beat leaves per point, in
// order, through 73 register stages: three for matrix products and sums,
// 67 in the two pipelined dividers running side by side (65 quotient-bit
// stages at sixteen fraction bits plus an input and an output register), then
// three for weights, index and bounds. The result is shown for one cycle with
// done high and cannot be held off. The divider depth sets the latency.
module project_point_bilinear_weights_core #(
	parameter int FRAC_BITS = ppbw_pkg::FRAC_BITS_DEF,
	parameter int DIM_BITS  = ppbw_pkg::DIM_BITS_DEF
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire  ppbw_pkg::point_t               point,
	output logic                                 done,
	output ppbw_pkg::result_t                    result,
	input  wire                                  cfg_we,
	input  wire  [ppbw_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire  [ppbw_pkg::CFG_DATA_W-1:0]      cfg_data
);
	localparam int DW    = DIM_BITS + 1;
	localparam int P_W   = 64;
	localparam int S_W   = 66 - FRAC_BITS;
	localparam int C_W   = FRAC_BITS + 17;
	localparam int COL_W = 17;
	localparam int IDX_W = ppbw_pkg::IDX_W;
	localparam int WGT_W = ppbw_pkg::WGT_W;
	localparam int TAG_W = 2;

	logic [63:0]   mat_q [6];
	logic [DW-1:0] width_q;
	logic [DW-1:0] height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				mat_q[i] <= '0;
			end
			width_q  <= DW'(ppbw_pkg::WIDTH_RESET);
			height_q <= DW'(ppbw_pkg::HEIGHT_RESET);
		end else if (cfg_we) begin
			unique case (cfg_index)
				ppbw_pkg::REG_ROW0_A: mat_q[0] <= cfg_data;
				ppbw_pkg::REG_ROW0_B: mat_q[1] <= cfg_data;
				ppbw_pkg::REG_ROW1_A: mat_q[2] <= cfg_data;
				ppbw_pkg::REG_ROW1_B: mat_q[3] <= cfg_data;
				ppbw_pkg::REG_ROW2_A: mat_q[4] <= cfg_data;
				ppbw_pkg::REG_ROW2_B: mat_q[5] <= cfg_data;
				ppbw_pkg::REG_WIDTH:  width_q  <= cfg_data[DW-1:0];
				ppbw_pkg::REG_HEIGHT: height_q <= cfg_data[DW-1:0];
				default: ;
			endcase
		end
	end

	assign busy = 1'b0;

	// Stage 1: nine products.
	logic             v_s1, v_s2, v_s3;
	logic signed [P_W-1:0] prod_s1 [9];
	logic signed [31:0]    tr_s1 [3];
	logic             last_s1, last_s2, last_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= start;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			prod_s1[3*r]   <= $signed(mat_q[2*r][31:0]) * point.pt_x;
			prod_s1[3*r+1] <= $signed(mat_q[2*r][63:32]) * point.pt_y;
			prod_s1[3*r+2] <= $signed(mat_q[2*r+1][31:0]) * point.pt_z;
			tr_s1[r]       <= $signed(mat_q[2*r+1][63:32]);
		end
		last_s1 <= point.last_point;
	end

	// Stage 2: floor each product to Q.16 and add pairs.
	logic signed [S_W-1:0] pa_s2 [3];
	logic signed [S_W-1:0] pb_s2 [3];
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			pa_s2[r] <= S_W'(prod_s1[3*r] >>> FRAC_BITS) +
				S_W'(prod_s1[3*r+1] >>> FRAC_BITS);
			pb_s2[r] <= S_W'(prod_s1[3*r+2] >>> FRAC_BITS) + S_W'(tr_s1[r]);
		end
		last_s2 <= last_s1;
	end

	// Stage 3: row sums.
	logic signed [S_W-1:0] sum_s3 [3];
	always_ff @(posedge clk) begin
		for (int r = 0; r < 3; r++) begin
			sum_s3[r] <= pa_s2[r] + pb_s2[r];
		end
		last_s3 <= last_s2;
	end

	logic dpos;
	assign dpos = !sum_s3[2][S_W-1] && (sum_s3[2] != '0);

	logic                    du_v, dv_v;
	logic signed [C_W-1:0]   cu, cv;
	logic [TAG_W-1:0]        tag_u, tag_v;

	ppbw_divider #(.FRAC_BITS(FRAC_BITS), .NUM_W(S_W), .TAG_W(TAG_W)) u_div_u (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s3), .num(sum_s3[0]),
		.den(dpos ? sum_s3[2][S_W-2:0] : (S_W-1)'(1)), .tag_in({last_s3, dpos}),
		.out_valid(du_v), .coord(cu), .tag_out(tag_u)
	);
	ppbw_divider #(.FRAC_BITS(FRAC_BITS), .NUM_W(S_W), .TAG_W(TAG_W)) u_div_v (
		.clk(clk), .arst_n(arst_n), .in_valid(v_s3), .num(sum_s3[1]),
		.den(dpos ? sum_s3[2][S_W-2:0] : (S_W-1)'(1)), .tag_in({last_s3, dpos}),
		.out_valid(dv_v), .coord(cv), .tag_out(tag_v)
	);

	// Stage 4: split into integer and fraction, index product.
	logic                    v_s4, v_s5;
	logic                    ok_s4, ok_s5, last_s4, last_s5;
	logic signed [COL_W-1:0] col_s4, row_s4;
	logic [FRAC_BITS:0]      fx_s4, fy_s4, wx_s4, wy_s4;
	logic signed [COL_W+DW:0] rw_s4;
	logic signed [COL_W-1:0] coln, rown;
	assign coln = COL_W'(cu >>> FRAC_BITS);
	assign rown = COL_W'(cv >>> FRAC_BITS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s4 <= du_v & dv_v;
			v_s5 <= v_s4;
			done <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		ok_s4   <= tag_u[0] & tag_v[0];
		last_s4 <= tag_u[1];
		col_s4  <= coln;
		row_s4  <= rown;
		fx_s4   <= {1'b0, cu[FRAC_BITS-1:0]};
		fy_s4   <= {1'b0, cv[FRAC_BITS-1:0]};
		wx_s4   <= (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, cu[FRAC_BITS-1:0]};
		wy_s4   <= (FRAC_BITS+1)'(1 << FRAC_BITS) - {1'b0, cv[FRAC_BITS-1:0]};
		rw_s4   <= rown * $signed({1'b0, width_q});
	end

	// Stage 5: weights, index, bounds.
	logic [2*FRAC_BITS+1:0] wtl_s5, wtr_s5, wbl_s5, wbr_s5;
	logic signed [IDX_W-1:0] idx_s5;
	logic                    inb_s5;
	logic signed [COL_W+DW:0] wm1, hm1;
	assign wm1 = $signed({{(COL_W+1){1'b0}}, width_q}) - 1;
	assign hm1 = $signed({{(COL_W+1){1'b0}}, height_q}) - 1;

	always_ff @(posedge clk) begin
		ok_s5   <= ok_s4;
		last_s5 <= last_s4;
		wtl_s5  <= wx_s4 * wy_s4;
		wtr_s5  <= fx_s4 * wy_s4;
		wbl_s5  <= wx_s4 * fy_s4;
		wbr_s5  <= fx_s4 * fy_s4;
		idx_s5  <= IDX_W'(rw_s4 + (COL_W+DW+1)'(col_s4));
		inb_s5  <= !col_s4[COL_W-1] && !row_s4[COL_W-1] &&
			((COL_W+DW+1)'(col_s4) < wm1) && ((COL_W+DW+1)'(row_s4) < hm1);
	end

	always_ff @(posedge clk) begin
		result.last_out <= last_s5;
		if (ok_s5) begin
			result.pixel_index <= idx_s5;
			result.in_bounds   <= inb_s5;
			result.weight_tl   <= WGT_W'(wtl_s5 >> FRAC_BITS);
			result.weight_tr   <= WGT_W'(wtr_s5 >> FRAC_BITS);
			result.weight_bl   <= WGT_W'(wbl_s5 >> FRAC_BITS);
			result.weight_br   <= WGT_W'(wbr_s5 >> FRAC_BITS);
		end else begin
			result.pixel_index <= '0;
			result.in_bounds   <= 1'b0;
			result.weight_tl   <= '0;
			result.weight_tr   <= '0;
			result.weight_bl   <= '0;
			result.weight_br   <= '0;
		end
	end
endmodule
`default_nettype wire
